### rtl/mpbm_pkg.sv
`default_nettype none
package mpbm_pkg;

  // Table geometry
  localparam int unsigned NodeW    = 8;
  localparam int unsigned SymW     = 8;
  localparam int unsigned GotoAw   = NodeW + SymW;
  localparam int unsigned NumNodes = 1 << NodeW;
  localparam int unsigned NumSyms  = 1 << SymW;
  localparam int unsigned GotoDepth = 1 << GotoAw;
  localparam int unsigned NumPat   = 16;
  localparam int unsigned PatW     = 4;
  localparam int unsigned PatCntW  = 5;
  localparam int unsigned LenW     = 9;
  localparam int unsigned PosW     = 32;
  localparam int unsigned StW      = 3;

  localparam logic [NodeW:0]   MaxStates = 9'd256;
  localparam logic [PatCntW-1:0] MaxPat  = 5'd16;

  // Request codes
  localparam logic [1:0] REQ_PATTERN = 2'd0;
  localparam logic [1:0] REQ_BUILD   = 2'd1;
  localparam logic [1:0] REQ_TEXT    = 2'd2;
  localparam logic [1:0] REQ_CLEAR   = 2'd3;

  // Result status codes
  localparam logic [StW-1:0] ST_OK         = 3'd0;
  localparam logic [StW-1:0] ST_MATCH      = 3'd1;
  localparam logic [StW-1:0] ST_OVERFLOW   = 3'd2;
  localparam logic [StW-1:0] ST_NOT_BUILT  = 3'd3;
  localparam logic [StW-1:0] ST_BUILD_DONE = 3'd4;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_OWAIT,
    S_P_RD,
    S_P_EVAL,
    S_P_MRD,
    S_P_MWR,
    S_T_RD,
    S_T_EVAL,
    S_T_FWAIT,
    S_T_MRD,
    S_T_MSET,
    S_T_EMIT,
    S_B_RRD,
    S_B_REVAL,
    S_B_DEQ,
    S_B_QWAIT,
    S_B_FCUR,
    S_B_CRD,
    S_B_CEVAL,
    S_B_BCHK,
    S_B_BEVAL,
    S_B_BFW,
    S_B_ZEVAL,
    S_B_LINK,
    S_B_MT,
    S_B_MN
  } state_e;

endpackage
`default_nettype wire

### rtl/multi_pattern_byte_matcher.sv
`default_nettype none
// Aho-Corasick matcher for up to 16 byte patterns over 256 trie states. Items are
// taken one at a time; in_ready_o is high only while the sequencer is idle. After
// reset and after every clear request the goto memory is swept, one entry a cycle,
// before the first item is taken. A pattern byte reads the goto memory, then adds a
// trie state if needed; a byte that ends a pattern also reads and writes the match
// memory, and a refused byte only gives its result. A text byte refused before a
// build gives only its result. Any other text byte takes the goto lookup and its
// failure-link steps, a match-memory read, a walk over pattern ids up to the
// highest one that matches, and one result per match (one when nothing matches),
// each waiting at the output until taken. The goto memory has a single read port.
// A build walks every state in breadth-first order and reads all 256 goto
// entries of each, following the failure chain for each child that it finds.
module multi_pattern_byte_matcher
  import mpbm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        req_type_i,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              item_last_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [StW-1:0]         status_o,
  output logic [PatW-1:0]        pattern_id_o,
  output logic [PosW-1:0]        match_start_o,
  output logic [PosW-1:0]        match_end_o,
  output logic                   run_last_o
);

  state_e state_q, state_d;

  // Memories
  logic [NodeW:0]      goto_mem  [GotoDepth];
  logic [NodeW-1:0]    fail_mem  [NumNodes];
  logic [NumPat-1:0]   match_mem [NumNodes];
  logic [NodeW-1:0]    queue_mem [NumNodes];

  logic [GotoAw-1:0]   goto_raddr, goto_waddr;
  logic [NodeW:0]      goto_rdata_q, goto_wdata;
  logic                goto_we;
  logic [NodeW-1:0]    fail_raddr, fail_waddr, fail_wdata, fail_rdata_q;
  logic                fail_we;
  logic [NodeW-1:0]    match_raddr, match_waddr;
  logic [NumPat-1:0]   match_wdata, match_rdata_q;
  logic                match_we;
  logic [NodeW-1:0]    queue_raddr, queue_waddr, queue_wdata, queue_rdata_q;
  logic                queue_we;

  // Control and datapath registers
  logic [GotoAw-1:0]   sweep_q;
  logic                clr_req_q;
  logic [SymW-1:0]     sym_q;
  logic                last_q;
  logic [NodeW:0]      states_used_q;
  logic [NodeW-1:0]    load_node_q;
  logic [LenW-1:0]     load_len_q;
  logic                dropped_q;
  logic [PatCntW-1:0]  pat_cnt_q;
  logic [NodeW-1:0]    scan_node_q;
  logic [PosW-1:0]     pos_q;
  logic                built_q;
  logic [LenW-1:0]     plen_q [NumPat];
  logic [NodeW-1:0]    cur_q, nxt_q, brd_q, curfail_q, tgt_q;
  logic [SymW-1:0]     a_q;
  logic [NodeW:0]      head_q, tail_q;
  logic [NumPat-1:0]   set_q, tmask_q;
  logic [PatW-1:0]     id_q;
  logic [PosW-1:0]     end_q;

  logic                in_fire;
  logic                present;
  logic [NodeW-1:0]    gtgt;
  logic                drop_new;
  logic [NodeW-1:0]    tgt_fix;
  logic [NumPat-1:0]   id_bit;
  logic [LenW-1:0]     cur_len;
  logic [PosW-1:0]     cur_start;
  logic                sweep_end;

  logic                emit;
  logic [StW-1:0]      emit_status;
  logic [PatW-1:0]     emit_id;
  logic [PosW-1:0]     emit_start, emit_end;
  logic                emit_last;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign present    = goto_rdata_q[NodeW];
  assign gtgt       = goto_rdata_q[NodeW-1:0];
  assign drop_new   = !present && (states_used_q >= MaxStates);
  assign tgt_fix    = (tgt_q == nxt_q) ? '0 : tgt_q;
  assign id_bit     = NumPat'(1) << id_q;
  assign cur_len    = plen_q[id_q];
  assign cur_start  = (PosW'(cur_len) > end_q) ? '0 : end_q - PosW'(cur_len);
  assign sweep_end  = (sweep_q == '1);

  // Memory ports: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (goto_we) goto_mem[goto_waddr] <= goto_wdata;
    goto_rdata_q <= goto_mem[goto_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (fail_we) fail_mem[fail_waddr] <= fail_wdata;
    fail_rdata_q <= fail_mem[fail_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (match_we) match_mem[match_waddr] <= match_wdata;
    match_rdata_q <= match_mem[match_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (queue_we) queue_mem[queue_waddr] <= queue_wdata;
    queue_rdata_q <= queue_mem[queue_raddr];
  end

  // Memory addressing, write enables and result generation
  always_comb begin
    goto_raddr  = {load_node_q, sym_q};
    goto_waddr  = {load_node_q, sym_q};
    goto_wdata  = '0;
    goto_we     = 1'b0;
    fail_raddr  = cur_q;
    fail_waddr  = nxt_q;
    fail_wdata  = '0;
    fail_we     = 1'b0;
    match_raddr = cur_q;
    match_waddr = nxt_q;
    match_wdata = '0;
    match_we    = 1'b0;
    queue_raddr = head_q[NodeW-1:0];
    queue_waddr = tail_q[NodeW-1:0];
    queue_wdata = nxt_q;
    queue_we    = 1'b0;
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_id     = '0;
    emit_start  = '0;
    emit_end    = '0;
    emit_last   = 1'b1;
    unique case (state_q)
      S_CLEAR: begin
        goto_we    = 1'b1;
        goto_waddr = sweep_q;
        if (sweep_q[GotoAw-1:NodeW] == '0) begin
          fail_we     = 1'b1;
          fail_waddr  = sweep_q[NodeW-1:0];
          match_we    = 1'b1;
          match_waddr = sweep_q[NodeW-1:0];
        end
        if (sweep_end && clr_req_q) emit = 1'b1;
      end
      S_IDLE: begin
        if (in_fire) begin
          unique case (req_type_i)
            REQ_PATTERN: begin
              if (pat_cnt_q >= MaxPat || dropped_q) begin
                emit        = 1'b1;
                emit_status = ST_OVERFLOW;
              end
            end
            REQ_TEXT: begin
              if (!built_q) begin
                emit        = 1'b1;
                emit_status = ST_NOT_BUILT;
              end
            end
            default: ;
          endcase
        end
      end
      S_P_RD: goto_raddr = {load_node_q, sym_q};
      S_P_EVAL: begin
        if (!present && !drop_new) begin
          goto_we    = 1'b1;
          goto_wdata = {1'b1, states_used_q[NodeW-1:0]};
          fail_we    = 1'b1;
          fail_waddr = states_used_q[NodeW-1:0];
          match_we   = 1'b1;
          match_waddr = states_used_q[NodeW-1:0];
        end
        if (!(last_q && !drop_new)) begin
          emit        = 1'b1;
          emit_status = drop_new ? ST_OVERFLOW : ST_OK;
        end
      end
      S_P_MRD: match_raddr = load_node_q;
      S_P_MWR: begin
        match_we    = 1'b1;
        match_waddr = load_node_q;
        match_wdata = match_rdata_q | (NumPat'(1) << pat_cnt_q[PatW-1:0]);
        emit        = 1'b1;
      end
      S_T_RD:   goto_raddr = {cur_q, sym_q};
      S_T_EVAL: fail_raddr = cur_q;
      S_T_MRD:  match_raddr = cur_q;
      S_T_EMIT: begin
        if (set_q == '0) begin
          emit     = 1'b1;
          emit_end = end_q;
        end else if (set_q[id_q]) begin
          emit        = 1'b1;
          emit_status = ST_MATCH;
          emit_id     = id_q;
          emit_start  = cur_start;
          emit_end    = end_q;
          emit_last   = ((set_q & ~id_bit) == '0);
        end
      end
      S_B_RRD: goto_raddr = {NodeW'(0), a_q};
      S_B_REVAL: begin
        if (present && gtgt != '0 && !tail_q[NodeW]) begin
          fail_we     = 1'b1;
          fail_waddr  = gtgt;
          queue_we    = 1'b1;
          queue_wdata = gtgt;
        end
      end
      S_B_DEQ: begin
        queue_raddr = head_q[NodeW-1:0];
        if (head_q == tail_q) begin
          emit        = 1'b1;
          emit_status = ST_BUILD_DONE;
        end
      end
      S_B_QWAIT: fail_raddr = queue_rdata_q;
      S_B_CRD:   goto_raddr = {cur_q, a_q};
      S_B_BCHK:  goto_raddr = (brd_q != '0) ? {brd_q, a_q} : {NodeW'(0), a_q};
      S_B_BEVAL: fail_raddr = brd_q;
      S_B_LINK: begin
        fail_we     = 1'b1;
        fail_waddr  = nxt_q;
        fail_wdata  = tgt_fix;
        match_raddr = tgt_fix;
      end
      S_B_MT: match_raddr = nxt_q;
      S_B_MN: begin
        match_we    = 1'b1;
        match_waddr = nxt_q;
        match_wdata = match_rdata_q | tmask_q;
        queue_we    = !tail_q[NodeW];
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR:  if (sweep_end) state_d = clr_req_q ? S_OWAIT : S_IDLE;
      S_IDLE: begin
        if (in_fire) begin
          unique case (req_type_i)
            REQ_PATTERN: state_d = emit ? S_OWAIT : S_P_RD;
            REQ_BUILD:   state_d = S_B_RRD;
            REQ_TEXT:    state_d = emit ? S_OWAIT : S_T_RD;
            REQ_CLEAR:   state_d = S_CLEAR;
            default:     state_d = S_IDLE;
          endcase
        end
      end
      S_OWAIT:  if (out_ready_i) state_d = run_last_o ? S_IDLE : S_T_EMIT;
      S_P_RD:   state_d = S_P_EVAL;
      S_P_EVAL: state_d = emit ? S_OWAIT : S_P_MRD;
      S_P_MRD:  state_d = S_P_MWR;
      S_P_MWR:  state_d = S_OWAIT;
      S_T_RD:   state_d = S_T_EVAL;
      S_T_EVAL: state_d = (!present && cur_q != '0) ? S_T_FWAIT : S_T_MRD;
      S_T_FWAIT: state_d = S_T_RD;
      S_T_MRD:  state_d = S_T_MSET;
      S_T_MSET: state_d = S_T_EMIT;
      S_T_EMIT: if (emit) state_d = S_OWAIT;
      S_B_RRD:  state_d = S_B_REVAL;
      S_B_REVAL: state_d = (a_q == '1) ? S_B_DEQ : S_B_RRD;
      S_B_DEQ:  state_d = (head_q == tail_q) ? S_OWAIT : S_B_QWAIT;
      S_B_QWAIT: state_d = S_B_FCUR;
      S_B_FCUR: state_d = S_B_CRD;
      S_B_CRD:  state_d = S_B_CEVAL;
      S_B_CEVAL: begin
        if (present) state_d = S_B_BCHK;
        else         state_d = (a_q == '1) ? S_B_DEQ : S_B_CRD;
      end
      S_B_BCHK:  state_d = (brd_q != '0) ? S_B_BEVAL : S_B_ZEVAL;
      S_B_BEVAL: state_d = present ? S_B_LINK : S_B_BFW;
      S_B_BFW:   state_d = S_B_BCHK;
      S_B_ZEVAL: state_d = S_B_LINK;
      S_B_LINK:  state_d = S_B_MT;
      S_B_MT:    state_d = S_B_MN;
      S_B_MN:    state_d = (a_q == '1) ? S_B_DEQ : S_B_CRD;
      default:   state_d = S_IDLE;
    endcase
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLEAR;
    else         state_q <= state_d;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q       <= '0;
      clr_req_q     <= 1'b0;
      states_used_q <= (NodeW+1)'(1);
      load_node_q   <= '0;
      load_len_q    <= '0;
      dropped_q     <= 1'b0;
      pat_cnt_q     <= '0;
      scan_node_q   <= '0;
      pos_q         <= '0;
      built_q       <= 1'b0;
      head_q        <= '0;
      tail_q        <= '0;
      a_q           <= '0;
      cur_q         <= '0;
      set_q         <= '0;
      id_q          <= '0;
    end else begin
      unique case (state_q)
        S_CLEAR: sweep_q <= sweep_q + GotoAw'(1);
        S_IDLE: begin
          if (in_fire) begin
            unique case (req_type_i)
              REQ_PATTERN: begin
                built_q <= 1'b0;
                if ((pat_cnt_q >= MaxPat || dropped_q) && item_last_i) begin
                  load_node_q <= '0;
                  load_len_q  <= '0;
                  dropped_q   <= 1'b0;
                end
              end
              REQ_BUILD: begin
                head_q <= '0;
                tail_q <= '0;
                a_q    <= '0;
              end
              REQ_TEXT: begin
                if (!built_q) begin
                  if (item_last_i) begin
                    scan_node_q <= '0;
                    pos_q       <= '0;
                  end
                end else begin
                  cur_q <= scan_node_q;
                end
              end
              REQ_CLEAR: begin
                sweep_q       <= '0;
                clr_req_q     <= 1'b1;
                states_used_q <= (NodeW+1)'(1);
                load_node_q   <= '0;
                load_len_q    <= '0;
                dropped_q     <= 1'b0;
                pat_cnt_q     <= '0;
                scan_node_q   <= '0;
                pos_q         <= '0;
                built_q       <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_P_EVAL: begin
          if (last_q && drop_new) begin
            // Pattern ends while overflowed: go back to the root
            load_node_q <= '0;
            load_len_q  <= '0;
            dropped_q   <= 1'b0;
          end else begin
            if (present) begin
              load_node_q <= gtgt;
            end else if (!drop_new) begin
              load_node_q   <= states_used_q[NodeW-1:0];
              states_used_q <= states_used_q + (NodeW+1)'(1);
            end else begin
              dropped_q <= 1'b1;
            end
            if (load_len_q != '1) load_len_q <= load_len_q + LenW'(1);
          end
        end
        S_P_MWR: begin
          pat_cnt_q   <= pat_cnt_q + PatCntW'(1);
          load_node_q <= '0;
          load_len_q  <= '0;
          dropped_q   <= 1'b0;
        end
        S_T_EVAL:  if (present) cur_q <= gtgt;
        S_T_FWAIT: cur_q <= fail_rdata_q;
        S_T_MSET: begin
          set_q       <= match_rdata_q;
          id_q        <= '0;
          scan_node_q <= last_q ? '0 : cur_q;
          pos_q       <= last_q ? '0 : end_q;
        end
        S_T_EMIT: begin
          if (set_q != '0) begin
            set_q <= set_q & ~id_bit;
            id_q  <= id_q + PatW'(1);
          end
        end
        S_B_REVAL: begin
          if (present && gtgt != '0 && !tail_q[NodeW]) tail_q <= tail_q + (NodeW+1)'(1);
          a_q <= a_q + SymW'(1);
        end
        S_B_DEQ: begin
          if (head_q == tail_q) begin
            built_q     <= 1'b1;
            scan_node_q <= '0;
            pos_q       <= '0;
          end
        end
        S_B_QWAIT: begin
          cur_q  <= queue_rdata_q;
          head_q <= head_q + (NodeW+1)'(1);
        end
        S_B_FCUR: a_q <= '0;
        S_B_CEVAL: if (!present) a_q <= a_q + SymW'(1);
        S_B_MN: begin
          if (!tail_q[NodeW]) tail_q <= tail_q + (NodeW+1)'(1);
          a_q <= a_q + SymW'(1);
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sym_q  <= data_byte_i;
      last_q <= item_last_i;
      end_q  <= (pos_q == '1) ? pos_q : pos_q + PosW'(1);
    end
    if (state_q == S_P_MWR) plen_q[pat_cnt_q[PatW-1:0]] <= load_len_q;
    if (state_q == S_B_FCUR) curfail_q <= fail_rdata_q;
    if (state_q == S_B_CEVAL) begin
      nxt_q <= gtgt;
      brd_q <= curfail_q;
    end
    if (state_q == S_B_BEVAL && present) tgt_q <= gtgt;
    if (state_q == S_B_BFW) brd_q <= fail_rdata_q;
    if (state_q == S_B_ZEVAL) tgt_q <= present ? gtgt : '0;
    if (state_q == S_B_MT) tmask_q <= match_rdata_q;
  end

  // Output register: hold the result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (emit) begin
      out_valid_o <= 1'b1;
    end else if (state_q == S_OWAIT && out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      status_o      <= emit_status;
      pattern_id_o  <= emit_id;
      match_start_o <= emit_start;
      match_end_o   <= emit_end;
      run_last_o    <= emit_last;
    end
  end

endmodule
`default_nettype wire
